// ===== hw/rtl/single_bin_triangle_correlator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the single-bin triangle correlator
// Shared concurrent-check forms, all disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SINGLE_BIN_TRIANGLE_CORRELATOR_TOP_DEFINES_SVH
`define SINGLE_BIN_TRIANGLE_CORRELATOR_TOP_DEFINES_SVH

// Same-cycle implication
`define SBTC_ASSERT_IMP(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("sbtc: same-cycle check failed");

// Next-cycle implication
`define SBTC_ASSERT_NXT(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("sbtc: next-cycle check failed");

`endif

// ===== hw/rtl/sbtc_pkg.sv =====
// ----------------------------------------------------------------------------
// sbtc_pkg
// Types and constants shared by the single-bin triangle correlator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbtc_pkg;

  // Fixed arithmetic constants
  localparam int TRI_OFFSET = 64;  // triangle reference offset and quarter-cycle shift
  localparam int TERM_SHIFT = 6;   // product scaling
  localparam int AVG_SHIFT  = 3;   // average is held as 8x the sample

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_FREQ_STEP   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_PHASE = 1'b1;

  typedef struct packed {
    logic [9:0] sample;
    logic       last_sample;
  } sbtc_in_t;

  typedef struct packed {
    logic signed [15:0] in_phase_sum;
    logic signed [15:0] quadrature_sum;
  } sbtc_out_t;

  typedef struct packed {
    logic [15:0] frequency_step;
    logic [7:0]  start_phase;
  } sbtc_cfg_t;

endpackage

// ===== hw/rtl/sbtc_term.sv =====
// ----------------------------------------------------------------------------
// sbtc_term
// One triangle correlation term: floor(ac * (|ph| - 64) / 64), sign-extended.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbtc_term (
  input  logic signed [7:0]  ac,
  input  logic        [7:0]  ph,
  output logic        [15:0] term
);
  import sbtc_pkg::*;

  logic signed [8:0]  ph_ext;
  logic signed [8:0]  mag;
  logic signed [8:0]  ref_v;
  logic signed [17:0] prod;
  logic signed [17:0] scaled;

  // Triangle reference; a phase byte of -128 gives magnitude 128
  assign ph_ext = signed'({ph[7], ph});
  assign mag    = ph_ext[8] ? -ph_ext : ph_ext;
  assign ref_v  = mag - 9'(TRI_OFFSET);

  // Product and floor scaling
  assign prod   = 18'(ac) * 18'(ref_v);
  assign scaled = prod >>> TERM_SHIFT;
  assign term   = scaled[15:0];

endmodule

// ===== hw/rtl/sbtc_core.sv =====
// ----------------------------------------------------------------------------
// sbtc_core
// Running average, phase accumulator and I/Q sums, updated once per sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "single_bin_triangle_correlator_top_defines.svh"

module sbtc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               proc_en,
  input  sbtc_pkg::sbtc_in_t  item,
  input  sbtc_pkg::sbtc_cfg_t cfg,
  output sbtc_pkg::sbtc_out_t result
);
  import sbtc_pkg::*;

  logic [15:0] dc_avg_r,  dc_avg_nxt;
  logic [15:0] phase_r,   phase_nxt;
  logic [15:0] sum_i_r,   sum_i_nxt;
  logic [15:0] sum_q_r,   sum_q_nxt;
  logic        block_open_r;

  logic [15:0] dc_base;
  logic [15:0] phase_base;
  logic [15:0] sum_i_base;
  logic [15:0] sum_q_base;
  logic [7:0]  ac;
  logic [7:0]  ph_i;
  logic [7:0]  ph_q;
  logic [15:0] term_i;
  logic [15:0] term_q;

  // Block start seeds the state from the sample and start phase
  assign dc_base    = block_open_r ? dc_avg_r : (16'(item.sample) << AVG_SHIFT);
  assign phase_base = block_open_r ? phase_r  : {cfg.start_phase, 8'h00};
  assign sum_i_base = block_open_r ? sum_i_r  : 16'h0000;
  assign sum_q_base = block_open_r ? sum_q_r  : 16'h0000;

  // AC part, low byte only
  assign ac         = item.sample[7:0] - dc_base[AVG_SHIFT+7:AVG_SHIFT];
  assign dc_avg_nxt = dc_base + {{8{ac[7]}}, ac};

  // Reference phases: quadrature lags by a quarter cycle
  assign ph_i = phase_base[15:8];
  assign ph_q = ph_i - 8'(TRI_OFFSET);

  sbtc_term u_term_i (
    .ac   (signed'(ac)),
    .ph   (ph_i),
    .term (term_i)
  );

  sbtc_term u_term_q (
    .ac   (signed'(ac)),
    .ph   (ph_q),
    .term (term_q)
  );

  assign sum_i_nxt = sum_i_base + term_i;
  assign sum_q_nxt = sum_q_base + term_q;
  assign phase_nxt = phase_base + cfg.frequency_step;

  assign result.in_phase_sum   = signed'(sum_i_nxt);
  assign result.quadrature_sum = signed'(sum_q_nxt);

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_avg_r     <= '0;
      phase_r      <= '0;
      sum_i_r      <= '0;
      sum_q_r      <= '0;
      block_open_r <= 1'b0;
    end else if (proc_en) begin
      dc_avg_r     <= dc_avg_nxt;
      phase_r      <= phase_nxt;
      sum_i_r      <= sum_i_nxt;
      sum_q_r      <= sum_q_nxt;
      block_open_r <= !item.last_sample;
    end
  end

  // Checks
  `SBTC_ASSERT_NXT(a_last_closes, clk, rst_n, proc_en && item.last_sample, !block_open_r)
  `SBTC_ASSERT_NXT(a_mid_opens, clk, rst_n, proc_en && !item.last_sample, block_open_r)
  `SBTC_ASSERT_NXT(a_idle_holds, clk, rst_n, !proc_en, $stable(sum_i_r) && $stable(phase_r))

endmodule

// ===== hw/rtl/single_bin_triangle_correlator_top.sv =====
// ----------------------------------------------------------------------------
// single_bin_triangle_correlator_top
// Single-bin DFT-style correlator against I/Q triangle references.
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_valid / in_ready  sbtc_in_t  (sample, last_sample)
//   out_     out  out_valid/ out_ready sbtc_out_t (in_phase_sum, quadrature_sum)
//   cfg_     in   cfg_we               cfg_addr, cfg_wdata
//
// One sample per cycle sustained unless a last sample stalls; the accumulator update is
// combinational logic between the input register and the state/result registers.
// A last sample's transaction loads the input register; once it leaves that register
// its sums are loaded into the result register, which drives out_valid.
// A last sample stalls in the input register only while a result still waits
// to be taken; other samples never stall. Synchronous reset clears the valid flags,
// configuration and accumulator state.
`timescale 1ns / 1ps

`include "single_bin_triangle_correlator_top_defines.svh"

module single_bin_triangle_correlator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sbtc_pkg::sbtc_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sbtc_pkg::sbtc_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [sbtc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [sbtc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sbtc_pkg::*;

  sbtc_cfg_t cfg_r;
  logic      in_vld_r;
  sbtc_in_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  sbtc_out_t out_data_r;
  sbtc_out_t result;
  logic      out_free;
  logic      proc_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FREQ_STEP:   cfg_r.frequency_step <= cfg_wdata[15:0];
        CFG_START_PHASE: cfg_r.start_phase    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Flow control
  assign out_free = !out_vld_r || out_ready;
  assign proc_en  = in_vld_r && (!in_item_r.last_sample || out_free);
  assign in_ready = !in_vld_r || proc_en;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  sbtc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc_en (proc_en),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Result register
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (proc_en && in_item_r.last_sample) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && in_item_r.last_sample) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // Checks
  `SBTC_ASSERT_IMP(a_no_overwrite, clk, rst_n, proc_en && in_item_r.last_sample, out_free)
  `SBTC_ASSERT_NXT(a_result_shown, clk, rst_n, proc_en && in_item_r.last_sample, out_vld_r)
  `SBTC_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, in_vld_r && in_item_r.last_sample)

endmodule

// ===== tb/sbtc_sum_checker.sv =====
// ----------------------------------------------------------------------------
// sbtc_sum_checker
// Watches the sample, result and register ports of the correlator. It keeps
// its own copy of the registers and the block state, works out the I/Q sums
// that each closing sample should produce, and compares them, in order, with
// the result transactions taken from the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbtc_sum_checker
  import sbtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  sbtc_in_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  sbtc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatch_count,
  output int                    pending_count
);

  // Register copies
  logic [15:0] freq_step_q;
  logic [7:0]  start_phase_q;

  // Correlator state
  logic [15:0] dc_avg;
  logic [15:0] phase_acc;
  logic [15:0] sum_i;
  logic [15:0] sum_q;
  logic        block_open;

  sbtc_out_t   expected_sums[$];
  int          errors;

  // floor(u * (|ph| - 64) / 64); a phase byte of -128 gives +64
  function automatic logic [15:0] triangle_term(int u, int ph);
    int v;
    v = (ph < 0 ? -ph : ph) - TRI_OFFSET;
    return 16'((u * v) >>> TERM_SHIFT);
  endfunction

  // One sample through the correlator; a closing sample queues its sums
  task automatic correlate_sample(input sbtc_in_t s);
    logic [15:0]        diff;
    logic signed [7:0]  ac_byte;
    logic signed [7:0]  p_byte;
    logic signed [7:0]  q_byte;
    int                 u;
    sbtc_out_t          sums;
    if (!block_open) begin
      dc_avg    = 16'(s.sample) << AVG_SHIFT;
      phase_acc = {start_phase_q, 8'h00};
      sum_i     = '0;
      sum_q     = '0;
    end
    diff    = 16'(s.sample) - (dc_avg >> AVG_SHIFT);
    ac_byte = diff[7:0];
    u       = ac_byte;
    dc_avg  = dc_avg + 16'(u);

    p_byte = phase_acc[15:8];
    q_byte = 8'(int'(p_byte) - TRI_OFFSET);
    sum_i  = sum_i + triangle_term(u, p_byte);
    sum_q  = sum_q + triangle_term(u, q_byte);

    phase_acc = phase_acc + freq_step_q;

    if (s.last_sample) begin
      sums.in_phase_sum   = sum_i;
      sums.quadrature_sum = sum_q;
      expected_sums.push_back(sums);
      block_open = 1'b0;
    end else begin
      block_open = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    sbtc_out_t want;
    if (!rst_n) begin
      freq_step_q   = '0;
      start_phase_q = '0;
      dc_avg        = '0;
      phase_acc     = '0;
      sum_i         = '0;
      sum_q         = '0;
      block_open    = 1'b0;
      errors        = 0;
      expected_sums.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_FREQ_STEP:   freq_step_q = cfg_wdata;
          CFG_START_PHASE: start_phase_q = cfg_wdata[7:0];
          default: ;
        endcase
      end

      // sample transaction
      if (in_valid && in_ready) begin
        correlate_sample(in_data);
      end

      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result: in_phase_sum %0d, quadrature_sum %0d",
                 out_data.in_phase_sum, out_data.quadrature_sum);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (out_data.in_phase_sum !== want.in_phase_sum) begin
            $error("in_phase_sum: expected %0d, got %0d",
                   want.in_phase_sum, out_data.in_phase_sum);
            errors++;
          end
          if (out_data.quadrature_sum !== want.quadrature_sum) begin
            $error("quadrature_sum: expected %0d, got %0d",
                   want.quadrature_sum, out_data.quadrature_sum);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_sums.size();
  end

endmodule

// ===== tb/single_bin_triangle_correlator_top_test.sv =====
// ----------------------------------------------------------------------------
// single_bin_triangle_correlator_top_test
// Drives sample blocks into the correlator under a range of frequency steps
// and start phases: a directed set of extreme samples and phases first, then
// random blocks of mixed length and content, with random gaps on both sides
// and one long result stall. The checker beside the block predicts and
// compares every result; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module single_bin_triangle_correlator_top_test;
  import sbtc_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 950;
  localparam int MAX_GAP       = 16;
  localparam int PRESSURE_HOLD = 400;
  localparam int BURST_ITEMS   = 30;
  localparam int DRAIN_CYCLES  = 4;

  // Sample content styles
  localparam int STYLE_UNIFORM  = 0;
  localparam int STYLE_EXTREMES = 1;
  localparam int STYLE_NOISE    = 2;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sbtc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sbtc_out_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int mismatch_count;
  int pending_count;
  int cycle_count;
  int items_sent;
  bit tx_quiet;
  bit tx_burst;
  bit rx_quiet;
  bit hold_long;

  single_bin_triangle_correlator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  sbtc_sum_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        gap = PRESSURE_HOLD;
      end else begin
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        gap = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // One sample transaction; valid stays high across back-to-back samples
  task automatic send_sample(input logic [9:0] value, input logic closing);
    int gap;
    if ($urandom_range(0, 49) == 0) tx_quiet = !tx_quiet;
    gap = (tx_quiet || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_data.sample      <= value;
    in_data.last_sample <= closing;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [9:0] pick_sample(int style, logic [9:0] level);
    int x;
    case (style)
      STYLE_EXTREMES: x = $urandom_range(0, 1) ? 1023 : 0;
      STYLE_NOISE: begin
        x = int'(level) + $urandom_range(0, 64) - 32;
        if (x < 0) x = 0;
        if (x > 1023) x = 1023;
      end
      default: x = $urandom_range(0, 1023);
    endcase
    return 10'(x);
  endfunction

  // A run of samples; closed blocks end on a marked sample
  task automatic send_block(input int len, input int style, input logic [9:0] level,
                            input bit closed);
    for (int i = 0; i < len; i++) begin
      send_sample(pick_sample(style, level), closed && (i == len - 1));
    end
  endtask

  // Both registers, back to back
  task automatic set_config(input logic [15:0] freq, input logic [7:0] phase);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_FREQ_STEP;
    cfg_wdata <= freq;
    @(posedge clk);
    cfg_addr  <= CFG_START_PHASE;
    cfg_wdata <= {8'h00, phase};
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all sums to come back and the pipeline to empty; the first edge
  // lets the checker count the transaction that was just accepted
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_phase();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short blocks, now and then a long one that wraps the sums
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(100, 300);
    if (r < 5) return 1;
    return $urandom_range(2, 24);
  endfunction

  initial begin
    int  random_start;
    int  nblocks;
    bit  pressure_done;
    items_sent    = 0;
    pressure_done = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample blocks at both sample extremes, reset registers
    send_sample(10'd0, 1'b1);
    send_sample(10'd1023, 1'b1);

    // Phase held at the most negative byte
    settle();
    set_config(16'h0000, 8'h80);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b1);

    // Largest step, largest start phase
    settle();
    set_config(16'hFFFF, 8'hFF);
    for (int i = 0; i < 6; i++) begin
      send_sample((i % 2) ? 10'd0 : 10'd1023, i == 5);
    end

    // Quarter-cycle step
    settle();
    set_config(16'h4000, 8'h40);
    send_sample(10'd512, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b0);
    send_sample(10'd1023, 1'b0);
    send_sample(10'd0, 1'b1);

    // Phase crossing from +127 to -128
    settle();
    set_config(16'h0100, 8'h7F);
    send_sample(10'd300, 1'b0);
    send_sample(10'd700, 1'b0);
    send_sample(10'd300, 1'b1);

    // Random phases of blocks
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      settle();
      set_config(pick_freq(), pick_phase());
      nblocks = $urandom_range(1, 6);
      for (int b = 0; b < nblocks; b++) begin
        send_block(pick_len(), $urandom_range(STYLE_UNIFORM, STYLE_NOISE),
                   10'($urandom_range(0, 1023)), 1'b1);
      end

      // Result side holds off while closing samples keep coming
      if (!pressure_done && (items_sent - random_start >= RANDOM_ITEMS / 2)) begin
        pressure_done = 1'b1;
        hold_long     = 1'b1;
        tx_burst      = 1'b1;
        repeat (BURST_ITEMS) send_sample(10'($urandom_range(0, 1023)), 1'b1);
        tx_burst      = 1'b0;
      end

      // Leave a block open across the next register change
      if ($urandom_range(0, 3) == 0) begin
        send_block($urandom_range(1, 3), STYLE_UNIFORM, 10'd0, 1'b0);
      end
    end
    send_sample(10'($urandom_range(0, 1023)), 1'b1);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
